[sv/integer_to_radix_digits_top_macros.svh]
// assertion macros shared by the integer to radix digits block
`ifndef INTEGER_TO_RADIX_DIGITS_TOP_MACROS_SVH
`define INTEGER_TO_RADIX_DIGITS_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define IT2R_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("it2r: same-cycle check failed");

// next-cycle implication, checked outside reset
`define IT2R_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("it2r: next-cycle check failed");

`endif

[sv/it2r_pkg.sv]
// package with types, constants and helpers for the integer to radix digits block
`timescale 1ns / 1ps

package it2r_pkg;

  localparam int DEF_VALUE_BITS = 32;
  localparam int DEF_MAX_DIGITS = 32;
  localparam int QUEUE_DEPTH    = 2;
  localparam int BITS_PER_STEP  = 8;   // quotient bits resolved per divider cycle

  localparam int RADIX_W = 6;
  localparam int DIGIT_W = 6;
  localparam int CHAR_W  = 7;

  localparam logic [RADIX_W-1:0] RADIX_MIN  = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX  = 6'd36;
  localparam logic [DIGIT_W-1:0] DEC_DIGITS = 6'd10;
  localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0]  CHAR_A     = 7'h41;

  typedef struct packed {
    logic [31:0]        value;
    logic [RADIX_W-1:0] radix;
  } in_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] digit_char;
    logic              last;
    logic              bad_radix;
  } out_item_t;

  // classification travelling with each queued job
  typedef struct packed {
    logic               bad_radix;
    logic [RADIX_W-1:0] radix;
  } job_ctrl_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_DIV,
    BK_READ,
    BK_LOAD,
    BK_SEND
  } back_state_t;

  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < DEC_DIGITS) begin
      c = CHAR_ZERO + {1'b0, d};
    end else begin
      c = CHAR_A + {1'b0, d} - {1'b0, DEC_DIGITS};
    end
    return c;
  endfunction

endpackage

[sv/it2r_queue.sv]
// short job queue between front and back
`timescale 1ns / 1ps

module it2r_queue #(
  parameter int WIDTH = 39,
  parameter int DEPTH = it2r_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             do_push, do_pop;

  assign push_ready = (fill != CNT_W'(DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

[sv/it2r_front.sv]
// front end: takes input items, trims the value and classifies the radix
`timescale 1ns / 1ps

module it2r_front #(
  parameter int VALUE_BITS = it2r_pkg::DEF_VALUE_BITS
) (
  input  logic                                         job_valid,
  output logic                                         job_ready,
  input  it2r_pkg::in_item_t                           job,
  output logic                                         push_valid,
  input  logic                                         push_ready,
  output logic [VALUE_BITS+$bits(it2r_pkg::job_ctrl_t)-1:0] push_data
);

  import it2r_pkg::*;

  localparam int WIDE_W = (VALUE_BITS > 32) ? VALUE_BITS : 32;

  logic [WIDE_W-1:0]     value_wide;
  logic [VALUE_BITS-1:0] value_trim;
  job_ctrl_t             ctrl;

  always_comb begin
    value_wide     = WIDE_W'(job.value);
    value_trim     = value_wide[VALUE_BITS-1:0];
    ctrl.radix     = job.radix;
    ctrl.bad_radix = !(job.radix inside {[RADIX_MIN:RADIX_MAX]});
  end

  assign push_valid = job_valid;
  assign job_ready  = push_ready;
  assign push_data  = {ctrl, value_trim};

endmodule

[sv/it2r_back.sv]
// back end: digit-at-a-time divider, digit store and reversed character output
`timescale 1ns / 1ps

module it2r_back #(
  parameter int VALUE_BITS = it2r_pkg::DEF_VALUE_BITS,
  parameter int MAX_DIGITS = it2r_pkg::DEF_MAX_DIGITS
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         pop_valid,
  output logic                                         pop_ready,
  input  logic [VALUE_BITS+$bits(it2r_pkg::job_ctrl_t)-1:0] pop_data,
  output logic                                         digit_valid,
  input  logic                                         digit_ready,
  output it2r_pkg::out_item_t                          digit
);

  import it2r_pkg::*;

  localparam int STEPS  = (VALUE_BITS + BITS_PER_STEP - 1) / BITS_PER_STEP;
  localparam int WORK_W = STEPS * BITS_PER_STEP;
  localparam int STEP_W = $clog2(STEPS + 1);
  localparam int CNT_W  = $clog2(MAX_DIGITS + 1);
  localparam int IDX_W  = $clog2(MAX_DIGITS);

  back_state_t state, state_next;

  job_ctrl_t             job_ctrl;
  logic [VALUE_BITS-1:0] job_value;

  logic [WORK_W-1:0]  work, work_div;
  logic [RADIX_W-1:0] radix;
  logic [DIGIT_W-1:0] rem, rem_div;
  logic [STEP_W-1:0]  step;
  logic [CNT_W-1:0]   digit_count, count_inc;
  logic [IDX_W-1:0]   rd_idx, rd_addr;
  logic [DIGIT_W-1:0] digit_store [MAX_DIGITS];
  logic [DIGIT_W-1:0] rd_q;
  out_item_t          out_q;

  logic last_step, div_done, rd_en, rd_prev;

  assign {job_ctrl, job_value} = pop_data;

  // one divider cycle: BITS_PER_STEP restoring steps on a 6-bit remainder
  always_comb begin
    logic [DIGIT_W:0] trial;
    rem_div  = rem;
    work_div = work;
    for (int i = 0; i < BITS_PER_STEP; i++) begin
      trial    = {rem_div, work_div[WORK_W-1]};
      work_div = {work_div[WORK_W-2:0], 1'b0};
      if (trial >= {1'b0, radix}) begin
        rem_div     = DIGIT_W'(trial - {1'b0, radix});
        work_div[0] = 1'b1;
      end else begin
        rem_div = trial[DIGIT_W-1:0];
      end
    end
  end

  assign count_inc = digit_count + 1'b1;
  assign last_step = (step == STEP_W'(STEPS - 1));
  assign div_done  = last_step && ((work_div == '0) || (count_inc == CNT_W'(MAX_DIGITS)));
  assign rd_addr   = rd_prev ? rd_idx - 1'b1 : rd_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    pop_ready   = 1'b0;
    digit_valid = 1'b0;
    rd_en       = 1'b0;
    rd_prev     = 1'b0;
    case (state)
      BK_IDLE: begin
        pop_ready = 1'b1;
        if (pop_valid) begin
          state_next = job_ctrl.bad_radix ? BK_SEND : BK_DIV;
        end
      end
      BK_DIV: begin
        if (div_done) begin
          state_next = BK_READ;
        end
      end
      BK_READ: begin
        rd_en      = 1'b1;
        state_next = BK_LOAD;
      end
      BK_LOAD: begin
        state_next = BK_SEND;
      end
      BK_SEND: begin
        digit_valid = 1'b1;
        if (digit_ready) begin
          if (out_q.last) begin
            state_next = BK_IDLE;
          end else begin
            rd_en      = 1'b1;
            rd_prev    = 1'b1;
            state_next = BK_LOAD;
          end
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  // digit store, written while dividing, read back in reverse
  always_ff @(posedge clk) begin
    if (state == BK_DIV && last_step) begin
      digit_store[digit_count[IDX_W-1:0]] <= rem_div;
    end
    if (rd_en) begin
      rd_q <= digit_store[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      digit_count <= '0;
    end else if (state == BK_IDLE && pop_valid) begin
      digit_count <= '0;
    end else if (state == BK_DIV && last_step) begin
      digit_count <= count_inc;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      BK_IDLE: begin
        work  <= WORK_W'(job_value);
        radix <= job_ctrl.radix;
        rem   <= '0;
        step  <= '0;
        out_q <= '{digit_char: '0, last: 1'b1, bad_radix: 1'b1};
      end
      BK_DIV: begin
        work <= work_div;
        if (last_step) begin
          rem    <= '0;
          step   <= '0;
          rd_idx <= digit_count[IDX_W-1:0];
        end else begin
          rem  <= rem_div;
          step <= step + 1'b1;
        end
      end
      BK_LOAD: begin
        out_q <= '{digit_char: digit_to_ascii(rd_q), last: (rd_idx == '0), bad_radix: 1'b0};
      end
      BK_SEND: begin
        if (rd_prev) begin
          rd_idx <= rd_idx - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign digit = out_q;

endmodule

[sv/integer_to_radix_digits_top.sv]
// top level of the integer to radix digits block.
// each input item carries an unsigned value and a radix; the block returns the value
// written in that radix as ascii characters ('0'-'9' then 'A'-'Z'), most significant
// character first, one output item per character, with last set on the final one.
// a zero value gives the single character '0'. a radix outside 2..36 gives one output
// item with bad_radix and last set and digit_char zero. only the low VALUE_BITS bits
// of the value are used; at most MAX_DIGITS characters come out (the low digits).
// buffering: a two-entry queue sits between input and converter, so up to two items are
// taken while a conversion is running. the converter takes one job at a time: the shared
// divider resolves 8 quotient bits a cycle, each digit is one full pass over the value,
// and each character is one registered digit-store read, loaded into the output register
// and held there until the sink is ready. a bad radix skips the divider. at 32 bits,
// base 2 is the worst case.
`timescale 1ns / 1ps
`include "integer_to_radix_digits_top_macros.svh"

module integer_to_radix_digits_top #(
  parameter int VALUE_BITS = it2r_pkg::DEF_VALUE_BITS,
  parameter int MAX_DIGITS = it2r_pkg::DEF_MAX_DIGITS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                job_valid,
  output logic                job_ready,
  input  it2r_pkg::in_item_t  job,
  output logic                digit_valid,
  input  logic                digit_ready,
  output it2r_pkg::out_item_t digit
);

  import it2r_pkg::*;

  // queued job: classification plus trimmed value
  localparam int Q_W = VALUE_BITS + $bits(job_ctrl_t);

  logic           push_valid, push_ready;
  logic [Q_W-1:0] push_data;
  logic           pop_valid, pop_ready;
  logic [Q_W-1:0] pop_data;

  // output item shape, used by the checks below
  logic bad_shape, char_ok, last_taken;

  // front: trims the value and flags a bad radix
  it2r_front #(
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .job_valid  (job_valid),
    .job_ready  (job_ready),
    .job        (job),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // job queue decoupling front from converter
  it2r_queue #(
    .WIDTH (Q_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // back: divider, digit store and character output register
  it2r_back #(
    .VALUE_BITS (VALUE_BITS),
    .MAX_DIGITS (MAX_DIGITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .pop_valid   (pop_valid),
    .pop_ready   (pop_ready),
    .pop_data    (pop_data),
    .digit_valid (digit_valid),
    .digit_ready (digit_ready),
    .digit       (digit)
  );

  // error item: final, no character
  assign bad_shape  = digit.last && (digit.digit_char == '0);
  // decimal digit or upper-case letter
  assign char_ok    = ((digit.digit_char >= CHAR_ZERO) && (digit.digit_char <= 7'h39)) ||
                      ((digit.digit_char >= CHAR_A) && (digit.digit_char <= 7'h5A));
  assign last_taken = digit_valid && digit_ready && digit.last;

  // an error item is a lone, final item with no character
  `IT2R_ASSERT_NOW(a_bad_is_single, clk, rst, digit_valid && digit.bad_radix, bad_shape)

  // every normal item is a legal digit character
  `IT2R_ASSERT_NOW(a_char_legal, clk, rst, digit_valid && !digit.bad_radix, char_ok)

  // the converter only takes a job the queue holds
  `IT2R_ASSERT_NOW(a_pop_has_job, clk, rst, pop_ready && !pop_valid, !(pop_valid && pop_ready))

  // in the cycle after a delivered last item, the output is idle
  `IT2R_ASSERT_NEXT(a_gap_after_last, clk, rst, last_taken, !digit_valid)

endmodule
